// File: rtl/anfs_pkg.sv
// Shared types, constants and helpers of the Annex B NAL unit splitter.
// Used by the framer, the unit processor and the top level; no dependencies.
`default_nettype none

package anfs_pkg;

  // Fixed widths of the result fields, and the most results per action
  localparam int LEN_W       = 17;
  localparam int MB_W        = 16;
  localparam int PIC_W       = 16;
  localparam int MAX_RESULTS = 6;

  // NAL unit types that are kept
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;

  // Final byte of the 00 00 00 01 start code
  localparam logic [7:0] START_LAST = 8'h01;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef enum logic [1:0] {
    GP_ZEROS,
    GP_SUFFIX,
    GP_DONE
  } gphase_t;

  // Work handed from the framer to the unit processor for one input byte:
  // up to three committed bytes in stream order, then optionally a unit end.
  typedef struct packed {
    logic            valid;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            closes;
  } act_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       out_byte;
    logic [4:0]       unit_type;
    logic [1:0]       ref_idc;
    logic             forbidden_bit;
    logic             kept;
    logic [MB_W-1:0]  first_mb;
    logic             new_picture;
    logic             frame_done;
    logic [LEN_W-1:0] unit_length;
    logic [PIC_W-1:0] picture_count;
    logic             last;
  } res_t;

  function automatic logic is_slice(input logic [4:0] t);
    return (t == NAL_SLICE) || (t == NAL_IDR);
  endfunction

  function automatic logic is_kept(input logic [4:0] t);
    return (t == NAL_SLICE) || (t == NAL_IDR) || (t == NAL_SPS) || (t == NAL_PPS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/anfs_in_if.sv
// Byte stream channel of the NAL unit splitter: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface anfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// File: rtl/anfs_out_if.sv
// Result channel of the NAL unit splitter: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface anfs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [4:0]  unit_type;
  logic [1:0]  ref_idc;
  logic        forbidden_bit;
  logic        kept;
  logic [15:0] first_mb;
  logic        new_picture;
  logic        frame_done;
  logic [16:0] unit_length;
  logic [15:0] picture_count;
  logic        last;

  modport source (
    output valid, input ready,
    output kind, output out_byte, output unit_type, output ref_idc, output forbidden_bit,
    output kept, output first_mb, output new_picture, output frame_done,
    output unit_length, output picture_count, output last
  );
  modport sink (
    input valid, output ready,
    input kind, input out_byte, input unit_type, input ref_idc, input forbidden_bit,
    input kept, input first_mb, input new_picture, input frame_done,
    input unit_length, input picture_count, input last
  );
endinterface

`default_nettype wire

// File: rtl/anfs_framer.sv
// Start code search and end-of-unit lookahead of the NAL unit splitter.
// Turns each accepted byte into a registered action (committed bytes, unit end).
// Depends on anfs_pkg.
`default_nettype none

module anfs_framer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           eos,
  output logic           in_ready,
  input  logic           done,
  output anfs_pkg::act_t act
);

  logic           in_unit, in_unit_next;
  logic [23:0]    win, win_next;
  logic [1:0]     fill, fill_next;
  anfs_pkg::act_t act_next;
  logic           take;

  assign in_ready = !act.valid || done;
  assign take     = in_valid && in_ready;

  always_comb begin
    logic [2:0][7:0] lst;
    logic [1:0]      n;
    logic            ended;
    logic            closes;

    in_unit_next = in_unit;
    win_next     = win;
    fill_next    = fill;
    lst          = '0;
    n            = 2'd0;
    ended        = 1'b0;
    closes       = 1'b0;

    if (!in_unit) begin
      if (fill == 2'd3 && win == 24'd0 && in_byte == anfs_pkg::START_LAST && !eos) begin
        in_unit_next = 1'b1;
        win_next     = 24'd0;
        fill_next    = 2'd0;
      end else begin
        win_next = {win[15:0], in_byte};
        if (fill != 2'd3) fill_next = fill + 2'd1;
      end
      if (eos) begin
        win_next  = 24'd0;
        fill_next = 2'd0;
      end
    end else begin
      // inside a unit only the two newest bytes are held back
      priority if (fill == 2'd2 && win[15:0] == 16'd0 && in_byte == 8'd0) begin
        ended        = 1'b1;
        closes       = 1'b1;
        in_unit_next = 1'b0;
        win_next     = 24'd0;
        fill_next    = 2'd3;
      end else if (fill == 2'd0 && in_byte != 8'd0) begin
        lst[n] = in_byte;
        n      = n + 2'd1;
      end else if (fill == 2'd2) begin
        lst[n]    = win[15:8];
        n         = n + 2'd1;
        win_next  = {8'd0, win[7:0], in_byte};
        fill_next = 2'd2;
      end else begin
        win_next  = {8'd0, win[7:0], in_byte};
        fill_next = fill + 2'd1;
      end
      if (eos) begin
        if (!ended) begin
          if (fill_next >= 2'd2) begin
            lst[n] = win_next[15:8];
            n      = n + 2'd1;
          end
          if (fill_next >= 2'd1) begin
            lst[n] = win_next[7:0];
            n      = n + 2'd1;
          end
          closes = 1'b1;
        end
        win_next     = 24'd0;
        fill_next    = 2'd0;
        in_unit_next = 1'b0;
      end
    end

    act_next = act;
    if (take) begin
      act_next.valid  = (n != 2'd0) || closes;
      act_next.cnt    = n;
      act_next.bytes  = lst;
      act_next.closes = closes;
    end else if (done) begin
      act_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_unit <= 1'b0;
      win     <= 24'd0;
      fill    <= 2'd0;
      act     <= '0;
    end else begin
      if (take) begin
        in_unit <= in_unit_next;
        win     <= win_next;
        fill    <= fill_next;
      end
      act <= act_next;
    end
  end

  a_fill_in_unit: assert property (@(posedge clk) disable iff (rst)
    in_unit |-> (fill != 2'd3))
    else $error("window fill out of range inside a unit");

  a_act_nonempty: assert property (@(posedge clk) disable iff (rst)
    act.valid |-> (act.cnt != 2'd0 || act.closes))
    else $error("empty action loaded");

endmodule

`default_nettype wire

// File: rtl/anfs_unit.sv
// Unit processor of the NAL unit splitter: header capture, re-emission with a
// start code, first macroblock index decode, length and picture count, end records.
// Depends on anfs_pkg.
`default_nettype none

module anfs_unit #(
  parameter int MAX_UNIT_BYTES = 65536,
  parameter int FIRST_MB_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  anfs_pkg::act_t act,
  output logic           done,
  input  logic           out_ready,
  output logic           out_valid,
  output anfs_pkg::res_t res
);

  localparam int LW        = anfs_pkg::LEN_W;
  localparam int RAW_W     = FIRST_MB_BITS;
  localparam int VAL_W     = FIRST_MB_BITS + 1;
  localparam int LEN_CAP_I = (MAX_UNIT_BYTES < 131071) ? MAX_UNIT_BYTES : 131071;
  localparam logic [LW-1:0]    LEN_CAP  = LW'(LEN_CAP_I);
  localparam logic [VAL_W-1:0] MB_LIMIT = {1'b0, {RAW_W{1'b1}}};
  localparam logic [2:0] SEQ_ONE  = 3'd3;  // the 01 of the start code
  localparam logic [2:0] SEQ_LAST = 3'd4;  // header byte closes the sequence
  localparam logic [2:0] RES_MAX  = 3'(anfs_pkg::MAX_RESULTS);

  logic [1:0]                 pos, pos_next;
  logic [2:0]                 sub, sub_next;
  logic [2:0]                 rcnt, rcnt_next;
  logic                       hdr_seen, hdr_seen_next;
  logic [7:0]                 hdr, hdr_next;
  logic [LW-1:0]              len, len_next;
  anfs_pkg::gphase_t          gph, gph_next;
  logic [4:0]                 gzeros, gzeros_next;
  logic [4:0]                 gleft, gleft_next;
  logic [RAW_W-1:0]           graw, graw_next;
  logic [anfs_pkg::PIC_W-1:0] pic, pic_next;
  logic                       out_valid_next;
  anfs_pkg::res_t             res_next;

  logic                       go, is_commit, more_cmds;
  logic [7:0]                 cur;
  anfs_pkg::gphase_t          sp;
  logic [4:0]                 sz, sl;
  logic [RAW_W-1:0]           sr;
  logic [anfs_pkg::MB_W-1:0]  fm;
  logic                       emit_ok;

  assign go        = act.valid && (!out_valid || out_ready);
  assign is_commit = pos < act.cnt;
  assign more_cmds = ({1'b0, pos} + 3'd1) < {1'b0, act.cnt};

  always_comb begin
    unique case (pos)
      2'd0:    cur = act.bytes[0];
      2'd1:    cur = act.bytes[1];
      2'd2:    cur = act.bytes[2];
      default: cur = 8'd0;
    endcase
  end

  // exp-Golomb prefix/suffix, one committed byte MSB first
  always_comb begin
    sp = gph;
    sz = gzeros;
    sl = gleft;
    sr = graw;
    for (int i = 7; i >= 0; i--) begin
      unique case (sp)
        anfs_pkg::GP_ZEROS: begin
          if (cur[3'(i)]) begin
            sr = '0;
            if (sz == 5'd0) begin
              sp = anfs_pkg::GP_DONE;
            end else begin
              sl = sz;
              sp = anfs_pkg::GP_SUFFIX;
            end
          end else if (sz != 5'd31) begin
            sz = sz + 5'd1;
          end
        end
        anfs_pkg::GP_SUFFIX: begin
          sr = {sr[RAW_W-2:0], cur[3'(i)]};
          sl = sl - 5'd1;
          if (sl == 5'd0) sp = anfs_pkg::GP_DONE;
        end
        default: ;
      endcase
    end
  end

  // first_mb at unit end; missing suffix bits count as zero
  always_comb begin
    logic [VAL_W-1:0] v;
    logic [31:0]      v32;
    v = MB_LIMIT;
    if (gph != anfs_pkg::GP_ZEROS && {27'd0, gzeros} < 32'(FIRST_MB_BITS)) begin
      v = (VAL_W'(graw) << gleft) + ((VAL_W'(1) << gzeros) - VAL_W'(1));
      if (v > MB_LIMIT) v = MB_LIMIT;
    end
    v32 = 32'(v);
    fm  = (v32 > 32'd65535) ? 16'hFFFF : v32[15:0];
  end

  always_comb begin
    logic       emit, more, step_adv, slice, np;
    logic [7:0] h_out;
    logic [7:0] b_out;

    pos_next       = pos;
    sub_next       = sub;
    rcnt_next      = rcnt;
    hdr_seen_next  = hdr_seen;
    hdr_next       = hdr;
    len_next       = len;
    gph_next       = gph;
    gzeros_next    = gzeros;
    gleft_next     = gleft;
    graw_next      = graw;
    pic_next       = pic;
    res_next       = res;
    emit           = 1'b0;
    more           = 1'b0;
    step_adv       = 1'b0;
    slice          = anfs_pkg::is_slice(hdr[4:0]);
    np             = 1'b0;
    h_out          = hdr;
    b_out          = 8'd0;
    done           = 1'b0;
    emit_ok        = 1'b0;

    if (go) begin
      if (is_commit) begin
        if (sub != 3'd0) begin
          emit     = 1'b1;
          b_out    = (sub == SEQ_ONE) ? anfs_pkg::START_LAST :
                     (sub == SEQ_LAST) ? hdr : 8'd0;
          more     = (sub != SEQ_LAST) || (more_cmds && anfs_pkg::is_kept(hdr[4:0])) ||
                     act.closes;
          step_adv = (sub == SEQ_LAST);
          sub_next = (sub == SEQ_LAST) ? 3'd0 : sub + 3'd1;
        end else if (!hdr_seen) begin
          hdr_seen_next = 1'b1;
          hdr_next      = cur;
          h_out         = cur;
          len_next      = LW'(1);
          gph_next      = anfs_pkg::GP_ZEROS;
          gzeros_next   = 5'd0;
          gleft_next    = 5'd0;
          graw_next     = '0;
          if (anfs_pkg::is_kept(cur[4:0])) begin
            emit     = 1'b1;
            more     = 1'b1;
            sub_next = 3'd1;
          end else begin
            step_adv = 1'b1;
          end
        end else begin
          step_adv = 1'b1;
          if (len < LEN_CAP) len_next = len + LW'(1);
          if (anfs_pkg::is_kept(hdr[4:0])) begin
            emit  = 1'b1;
            b_out = cur;
            more  = more_cmds || act.closes;
          end
          if (slice) begin
            gph_next    = sp;
            gzeros_next = sz;
            gleft_next  = sl;
            graw_next   = sr;
          end
        end
        done = step_adv && !more_cmds && !act.closes;
      end else begin
        // end of unit: record, then back to waiting for a header
        np            = slice && (fm == 16'd0);
        if (np) pic_next = pic + anfs_pkg::PIC_W'(1);
        emit          = 1'b1;
        more          = 1'b0;
        hdr_seen_next = 1'b0;
        hdr_next      = 8'd0;
        done          = 1'b1;
      end

      emit_ok = emit && (rcnt < RES_MAX);
      if (emit_ok) begin
        res_next.kind          = is_commit ? anfs_pkg::KIND_BYTE : anfs_pkg::KIND_RECORD;
        res_next.out_byte      = b_out;
        res_next.unit_type     = h_out[4:0];
        res_next.ref_idc       = h_out[6:5];
        res_next.forbidden_bit = h_out[7];
        res_next.kept          = is_commit ? 1'b1 : anfs_pkg::is_kept(hdr[4:0]);
        res_next.first_mb      = (!is_commit && slice) ? fm : 16'd0;
        res_next.new_picture   = np;
        res_next.frame_done    = !is_commit && slice;
        res_next.unit_length   = (!is_commit && hdr_seen) ? len : LW'(0);
        res_next.picture_count = pic_next;
        res_next.last          = !more || (rcnt == RES_MAX - 3'd1);
      end

      if (done) begin
        pos_next  = 2'd0;
        rcnt_next = 3'd0;
      end else begin
        if (step_adv) pos_next = pos + 2'd1;
        rcnt_next = rcnt + {2'd0, emit_ok};
      end
    end

    out_valid_next = emit_ok ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      sub       <= 3'd0;
      rcnt      <= 3'd0;
      hdr_seen  <= 1'b0;
      hdr       <= 8'd0;
      len       <= '0;
      gph       <= anfs_pkg::GP_ZEROS;
      gzeros    <= 5'd0;
      gleft     <= 5'd0;
      graw      <= '0;
      pic       <= '0;
      out_valid <= 1'b0;
    end else begin
      pos       <= pos_next;
      sub       <= sub_next;
      rcnt      <= rcnt_next;
      hdr_seen  <= hdr_seen_next;
      hdr       <= hdr_next;
      len       <= len_next;
      gph       <= gph_next;
      gzeros    <= gzeros_next;
      gleft     <= gleft_next;
      graw      <= graw_next;
      pic       <= pic_next;
      out_valid <= out_valid_next;
    end
    res <= res_next;
  end

  a_rcnt_cap: assert property (@(posedge clk) disable iff (rst)
    rcnt <= RES_MAX)
    else $error("result count per transfer exceeds limit");

  a_seq_hdr: assert property (@(posedge clk) disable iff (rst)
    (sub != 3'd0) |-> (hdr_seen && act.valid && is_commit))
    else $error("start code sequence without a header");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    act.valid |-> (pos <= act.cnt))
    else $error("step index past the action");

  a_record_last: assert property (@(posedge clk) disable iff (rst)
    (go && !is_commit && rcnt < RES_MAX) |=> (out_valid && res.last && res.kind))
    else $error("end record not flagged last");

endmodule

`default_nettype wire

// File: rtl/annexb_nal_frame_splitter.sv
// H.264 Annex B NAL unit splitter, top level.
// Channels: stream (anfs_in_if) takes one byte per transfer with an
// end_of_stream flag on the final byte; result (anfs_out_if) gives emitted
// bytes (kind 0) and one end record per unit (kind 1), with last set on the
// final result caused by an input byte.
// Start codes 00 00 00 01 open a unit; three zero bytes or end of stream close
// it. Kept units (SPS, PPS, slices) are re-emitted behind a fresh start code.
// Path: a result is held in the action register, then the output register,
// on its way from the byte that causes it. Throughput: one byte per cycle while
// result.ready holds and each byte needs at most one step, a committed byte or a record;
// otherwise a byte occupies the processor for one step per committed byte or record,
// and a kept header byte takes steps for the bytes of its fresh start code and itself.
// Reset: searching for a start code, empty window, picture count zero.
// Stall: the output register holds its result and one more byte is taken into
// the action register; then stream.ready drops until result.ready returns.
// Depends on anfs_pkg, anfs_in_if, anfs_out_if, anfs_framer, anfs_unit.
`default_nettype none

module annexb_nal_frame_splitter #(
  parameter int MAX_UNIT_BYTES = 65536,
  parameter int FIRST_MB_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  anfs_in_if.sink    stream,
  anfs_out_if.source result
);

  anfs_pkg::act_t act;
  anfs_pkg::res_t res;
  logic           done;
  logic           in_ready;
  logic           out_valid;

  anfs_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_byte  (stream.in_byte),
    .eos      (stream.end_of_stream),
    .in_ready (in_ready),
    .done     (done),
    .act      (act)
  );

  anfs_unit #(
    .MAX_UNIT_BYTES (MAX_UNIT_BYTES),
    .FIRST_MB_BITS  (FIRST_MB_BITS)
  ) u_unit (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .done      (done),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign stream.ready         = in_ready;
  assign result.valid         = out_valid;
  assign result.kind          = res.kind;
  assign result.out_byte      = res.out_byte;
  assign result.unit_type     = res.unit_type;
  assign result.ref_idc       = res.ref_idc;
  assign result.forbidden_bit = res.forbidden_bit;
  assign result.kept          = res.kept;
  assign result.first_mb      = res.first_mb;
  assign result.new_picture   = res.new_picture;
  assign result.frame_done    = res.frame_done;
  assign result.unit_length   = res.unit_length;
  assign result.picture_count = res.picture_count;
  assign result.last          = res.last;

endmodule

`default_nettype wire

// File: dv/tb_annexb_nal_frame_splitter.sv
// Testbench of annexb_nal_frame_splitter: byte stream in, emitted bytes and end records out.
// Predicts results per accepted byte and checks each result transfer in order.
// Depends on anfs_pkg, anfs_in_if, anfs_out_if and the splitter RTL.

module tb_annexb_nal_frame_splitter;

  localparam int MAX_UNIT_BYTES = 65536;
  localparam int FIRST_MB_BITS  = 16;
  localparam int LEN_CAP        = (MAX_UNIT_BYTES < 131071) ? MAX_UNIT_BYTES : 131071;
  localparam logic [63:0] MB_MAX = (64'd1 << (FIRST_MB_BITS & 31)) - 64'd1;
  localparam logic [4:0] NAL_SEI = 5'd6;
  localparam int ITEM_TARGET  = 160;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst;

  anfs_in_if  stream_if ();
  anfs_out_if result_if ();

  annexb_nal_frame_splitter #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES),
    .FIRST_MB_BITS (FIRST_MB_BITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_if),
    .result(result_if)
  );

  always #4 clk = ~clk;

  // splitter state as seen from outside
  logic              unit_open;
  logic [23:0]       look_win;
  logic [1:0]        look_fill;
  logic              hdr_valid;
  logic [7:0]        hdr;
  anfs_pkg::gphase_t eg_phase;
  logic [4:0]        eg_zeros;
  logic [4:0]        eg_left;
  logic [63:0]       eg_val;
  logic [16:0]       unit_len;
  logic [15:0]       pic_cnt;
  int                step_results;

  anfs_pkg::res_t nal_out_q[$];
  anfs_pkg::res_t oldest;

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   sent_items = 0;
  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic hold_req = 1'b0;

  function automatic logic type_is_slice(input logic [4:0] t);
    return (t == anfs_pkg::NAL_SLICE) || (t == anfs_pkg::NAL_IDR);
  endfunction

  function automatic logic type_is_kept(input logic [4:0] t);
    return (t == anfs_pkg::NAL_SLICE) || (t == anfs_pkg::NAL_IDR) ||
           (t == anfs_pkg::NAL_SPS) || (t == anfs_pkg::NAL_PPS);
  endfunction

  function automatic logic [63:0] clip_mb(input logic [63:0] v);
    return (v > MB_MAX) ? MB_MAX : v;
  endfunction

  function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
    logic [31:0] r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  function automatic logic one_in(input int unsigned n);
    return $urandom_range(n - 1, 0) == 0;
  endfunction

  task automatic emit(input logic kind, input logic [7:0] b, input logic kp,
                      input logic [15:0] fm, input logic np, input logic fd,
                      input logic [16:0] len);
    anfs_pkg::res_t r;
    logic [7:0] h;
    if (step_results >= anfs_pkg::MAX_RESULTS) return;
    h = hdr_valid ? hdr : 8'h00;
    r.kind          = kind;
    r.out_byte      = b;
    r.unit_type     = h[4:0];
    r.ref_idc       = h[6:5];
    r.forbidden_bit = h[7];
    r.kept          = kp;
    r.first_mb      = fm;
    r.new_picture   = np;
    r.frame_done    = fd;
    r.unit_length   = len;
    r.picture_count = pic_cnt;
    r.last          = 1'b0;
    nal_out_q.push_back(r);
    step_results++;
  endtask

  task automatic shift_golomb_bit(input logic gb);
    case (eg_phase)
      anfs_pkg::GP_ZEROS: begin
        if (gb) begin
          eg_val = 64'd0;
          if (eg_zeros == 5'd0) begin
            eg_phase = anfs_pkg::GP_DONE;
          end else begin
            eg_left  = eg_zeros;
            eg_phase = anfs_pkg::GP_SUFFIX;
          end
        end else if (eg_zeros < 5'd31) begin
          eg_zeros++;
        end
      end
      anfs_pkg::GP_SUFFIX: begin
        eg_val = {eg_val[62:0], gb};
        eg_left--;
        if (eg_left == 5'd0) begin
          eg_val   = clip_mb(eg_val + ((64'd1 << eg_zeros) - 64'd1));
          eg_phase = anfs_pkg::GP_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // missing suffix bits read as zero; no 1 bit at all saturates
  function automatic logic [15:0] slice_first_mb();
    logic [63:0] v;
    if (eg_phase == anfs_pkg::GP_DONE)
      v = eg_val;
    else if (eg_phase == anfs_pkg::GP_SUFFIX)
      v = clip_mb((eg_val << eg_left) + ((64'd1 << eg_zeros) - 64'd1));
    else
      v = MB_MAX;
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic take_byte(input logic [7:0] b);
    int i;
    if (!hdr_valid) begin
      hdr       = b;
      hdr_valid = 1'b1;
      unit_len  = 17'd1;
      eg_phase  = anfs_pkg::GP_ZEROS;
      eg_zeros  = 5'd0;
      eg_left   = 5'd0;
      eg_val    = 64'd0;
      if (type_is_kept(b[4:0])) begin
        emit(anfs_pkg::KIND_BYTE, 8'h00, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
        emit(anfs_pkg::KIND_BYTE, 8'h00, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
        emit(anfs_pkg::KIND_BYTE, 8'h00, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
        emit(anfs_pkg::KIND_BYTE, anfs_pkg::START_LAST, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
        emit(anfs_pkg::KIND_BYTE, b, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
      end
    end else begin
      if (unit_len < LEN_CAP) unit_len++;
      if (type_is_kept(hdr[4:0]))
        emit(anfs_pkg::KIND_BYTE, b, 1'b1, 16'd0, 1'b0, 1'b0, 17'd0);
      if (type_is_slice(hdr[4:0]))
        for (i = 7; i >= 0; i--) shift_golomb_bit(b[i]);
    end
  endtask

  task automatic close_unit();
    logic [4:0]  t;
    logic        sl;
    logic [15:0] fm;
    logic        np;
    logic [16:0] len;
    t   = hdr_valid ? hdr[4:0] : 5'd0;
    sl  = type_is_slice(t);
    fm  = sl ? slice_first_mb() : 16'd0;
    np  = sl && (fm == 16'd0);
    len = hdr_valid ? unit_len : 17'd0;
    if (np) pic_cnt++;
    emit(anfs_pkg::KIND_RECORD, 8'h00, type_is_kept(t), fm, np, sl, len);
    unit_open = 1'b0;
    hdr_valid = 1'b0;
  endtask

  task automatic split_byte(input logic [7:0] b, input logic eos);
    logic ended;
    anfs_pkg::res_t r;
    step_results = 0;
    ended = 1'b0;
    if (!unit_open) begin
      // a start code completed by the final byte opens nothing
      if (look_fill == 2'd3 && look_win == 24'd0 && b == anfs_pkg::START_LAST && !eos) begin
        unit_open = 1'b1;
        hdr_valid = 1'b0;
        unit_len  = 17'd0;
        look_win  = 24'd0;
        look_fill = 2'd0;
      end else begin
        look_win = {look_win[15:0], b};
        if (look_fill < 2'd3) look_fill++;
      end
      if (eos) begin
        look_win  = 24'd0;
        look_fill = 2'd0;
      end
    end else begin
      if (look_fill == 2'd2 && look_win[15:0] == 16'd0 && b == 8'h00) begin
        // the three zeros stay behind as the prefix of the next start code
        close_unit();
        look_win  = 24'd0;
        look_fill = 2'd3;
        ended     = 1'b1;
      end else if (look_fill == 2'd0 && b != 8'h00) begin
        take_byte(b);
      end else if (look_fill >= 2'd2) begin
        take_byte(look_win[15:8]);
        look_win  = {8'h00, look_win[7:0], b};
        look_fill = 2'd2;
      end else begin
        look_win = {8'h00, look_win[7:0], b};
        look_fill++;
      end
      if (eos) begin
        if (!ended) begin
          if (look_fill >= 2'd2) take_byte(look_win[15:8]);
          if (look_fill >= 2'd1) take_byte(look_win[7:0]);
          close_unit();
        end
        look_win  = 24'd0;
        look_fill = 2'd0;
        unit_open = 1'b0;
      end
    end
    if (step_results > 0) begin
      r = nal_out_q.pop_back();
      r.last = 1'b1;
      nal_out_q.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(18, 0) : 0;
    if (gap > 0) begin
      stream_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_if.valid         <= 1'b1;
    stream_if.in_byte       <= b;
    stream_if.end_of_stream <= eos;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    sent_items++;
    split_byte(b, eos);
  endtask

  task automatic send_start_code();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(anfs_pkg::START_LAST, 1'b0);
  endtask

  task automatic send_start_code_at_end();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(anfs_pkg::START_LAST, 1'b1);
  endtask

  task automatic send_unit_end();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (nal_out_q.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_count++;
      end else begin
        oldest = nal_out_q.pop_front();
        check_field("kind", 32'(oldest.kind), 32'(result_if.kind));
        check_field("out_byte", 32'(oldest.out_byte), 32'(result_if.out_byte));
        check_field("unit_type", 32'(oldest.unit_type), 32'(result_if.unit_type));
        check_field("ref_idc", 32'(oldest.ref_idc), 32'(result_if.ref_idc));
        check_field("forbidden_bit", 32'(oldest.forbidden_bit),
                    32'(result_if.forbidden_bit));
        check_field("kept", 32'(oldest.kept), 32'(result_if.kept));
        check_field("first_mb", 32'(oldest.first_mb), 32'(result_if.first_mb));
        check_field("new_picture", 32'(oldest.new_picture), 32'(result_if.new_picture));
        check_field("frame_done", 32'(oldest.frame_done), 32'(result_if.frame_done));
        check_field("unit_length", 32'(oldest.unit_length), 32'(result_if.unit_length));
        check_field("picture_count", 32'(oldest.picture_count),
                    32'(result_if.picture_count));
        check_field("last", 32'(oldest.last), 32'(result_if.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_annexb_nal_frame_splitter: FAIL");
      $finish;
    end
  end

  // result side: random wait per transfer, plus one long hold on request
  initial begin
    int gap;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(18, 0) : 0;
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!(result_if.valid && result_if.ready) && !hold_req) @(posedge clk);
    end
  end

  // garbage before the first start code, then an SPS with the forbidden bit and both ref_idc bits set
  task automatic test_start_code_search();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_start_code();
    send_byte({1'b1, 2'd3, anfs_pkg::NAL_SPS}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_unit_end();
  endtask

  // each unit reuses the previous three zeros as its start code prefix
  task automatic test_unit_types();
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd3, anfs_pkg::NAL_IDR}, 1'b0);
    send_byte(8'h88, 1'b0);
    send_unit_end();
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd2, anfs_pkg::NAL_SLICE}, 1'b0);
    send_byte(8'h40, 1'b0);
    send_unit_end();
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd0, NAL_SEI}, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_unit_end();
    // empty unit
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_unit_end();
    // slice with no 1 bit before its end
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd1, anfs_pkg::NAL_SLICE}, 1'b0);
    send_unit_end();
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd1, anfs_pkg::NAL_PPS}, 1'b0);
    send_byte(8'h40, 1'b0);
    send_unit_end();
  endtask

  task automatic test_stream_end();
    // slice cut mid-suffix with two zeros still pending
    send_byte(anfs_pkg::START_LAST, 1'b0);
    send_byte({1'b0, 2'd1, anfs_pkg::NAL_SLICE}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(anfs_pkg::START_LAST, 1'b1);
    // start code finished by the final byte
    send_start_code_at_end();
    // header is the final byte: start code, header and record
    send_start_code();
    send_byte({1'b0, 2'd3, anfs_pkg::NAL_IDR}, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_output_stall();
    int i;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    send_start_code();
    send_byte({1'b0, 2'd3, anfs_pkg::NAL_PPS}, 1'b0);
    for (i = 0; i < 24; i++) send_byte(rand_byte(0, 255), 1'b0);
    send_unit_end();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_stream();
    int          plen;
    int          i;
    logic [7:0]  hb;
    logic [7:0]  pb;
    logic [4:0]  ty;
    logic        cut;
    logic [31:0] r;
    while (sent_items < ITEM_TARGET) begin
      if (one_in(6)) begin
        tx_idle = !one_in(4);
        rx_idle = !one_in(4);
      end
      if (one_in(5)) begin
        repeat ($urandom_range(6, 1)) begin
          pb = one_in(3) ? 8'h00 :
               (one_in(4) ? anfs_pkg::START_LAST : rand_byte(0, 255));
          send_byte(pb, one_in(16));
        end
      end else begin
        send_start_code();
        if (one_in(4)) begin
          r  = $urandom_range(31, 0);
          ty = r[4:0];
        end else begin
          r = $urandom_range(5, 0);
          case (r)
            0, 1: ty = anfs_pkg::NAL_SLICE;
            2, 3: ty = anfs_pkg::NAL_IDR;
            4:    ty = anfs_pkg::NAL_SPS;
            default: ty = anfs_pkg::NAL_PPS;
          endcase
        end
        hb      = rand_byte(0, 255);
        hb[4:0] = ty;
        plen    = $urandom_range(10, 0);
        cut     = one_in(8);
        send_byte(hb, cut && plen == 0);
        for (i = 0; i < plen; i++) begin
          r = $urandom_range(5, 0);
          case (r)
            0: pb = 8'h00;
            1: pb = 8'h80 >> $urandom_range(7, 0);
            default: pb = rand_byte(0, 255);
          endcase
          send_byte(pb, cut && i == plen - 1);
        end
        if (!cut) send_unit_end();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst                     <= 1'b1;
    stream_if.valid         <= 1'b0;
    stream_if.in_byte       <= 8'h00;
    stream_if.end_of_stream <= 1'b0;
    unit_open = 1'b0;
    look_win  = 24'd0;
    look_fill = 2'd0;
    hdr_valid = 1'b0;
    hdr       = 8'h00;
    eg_phase  = anfs_pkg::GP_ZEROS;
    eg_zeros  = 5'd0;
    eg_left   = 5'd0;
    eg_val    = 64'd0;
    unit_len  = 17'd0;
    pic_cnt   = 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_code_search();
    test_unit_types();
    test_stream_end();
    test_output_stall();
    test_random_stream();

    stream_if.valid <= 1'b0;
    while (nal_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_annexb_nal_frame_splitter: PASS");
    else
      $display("tb_annexb_nal_frame_splitter: FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/anfs_pkg.sv
rtl/anfs_in_if.sv
rtl/anfs_out_if.sv
rtl/anfs_framer.sv
rtl/anfs_unit.sv
rtl/annexb_nal_frame_splitter.sv
dv/tb_annexb_nal_frame_splitter.sv
